### hdl/r2p_pkg.sv
// ----------------------------------------------------------------------------
// r2p_pkg
// shared constants, arctangent table and pipeline control type for the
// rectangular to polar converter
// ----------------------------------------------------------------------------
package r2p_pkg;

  localparam int ITERATIONS_DEF = 16;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS      = 30;
  localparam int ATAN_ENTRIES   = 24;
  localparam int ANG_W          = 16;
  localparam int Z_W            = 32;

  // round(atan(2^-i) * 2^31 / pi)
  localparam logic [Z_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  localparam logic [Z_W-1:0]   Z_PI            = 32'h8000_0000;
  localparam logic [Z_W-1:0]   Z_ROUND         = 32'h0000_8000;
  localparam logic [ANG_W-1:0] ANG_ZERO        = 16'h0000;
  localparam logic [ANG_W-1:0] ANG_HALF_PI     = 16'h4000;
  localparam logic [ANG_W-1:0] ANG_NEG_HALF_PI = 16'hC000;
  localparam logic [ANG_W-1:0] ANG_PI          = 16'h8000;

  typedef struct packed {
    logic             valid;
    logic             special;
    logic [ANG_W-1:0] spec_angle;
  } r2p_ctl_t;

endpackage

### hdl/rect_to_polar.sv
// ----------------------------------------------------------------------------
// rect_to_polar
// rectangular to polar conversion: rounded magnitude by a digit-per-cell
// square root, four-quadrant binary angle by cordic vectoring
// ----------------------------------------------------------------------------
//  port group        dir  handshake      payload
//  sample            in   start / busy   real_part_i, imag_part_i
//  result            out  done_o strobe  magnitude_o, angle_o
//
//  one transaction is taken every clock; busy is never raised
//  each transaction passes the two entry stages, the cell row and the output stage;
//  the row is as long as ITERATIONS (capped at the table depth) or DATA_WIDTH
//  reset clears the valid bits of every stage; no transaction is lost or
//  invented across the row, and results are strobed for a single cycle
// ----------------------------------------------------------------------------
module rect_to_polar import r2p_pkg::*; #(
  parameter int ITERATIONS = ITERATIONS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] real_part_i,
  input  logic signed [DATA_WIDTH-1:0] imag_part_i,
  output logic                         done_o,
  output logic [DATA_WIDTH-1:0]        magnitude_o,
  output logic signed [ANG_W-1:0]      angle_o
);

  localparam int DW   = DATA_WIDTH;
  localparam int CW   = DW + FRAC_BITS + 2;
  localparam int NROT = (ITERATIONS < ATAN_ENTRIES) ? ITERATIONS : ATAN_ENTRIES;
  localparam int L    = (NROT > DW) ? NROT : DW;
  localparam int LAT  = L + 3;

  r2p_ctl_t             ctl_c  [L+1];
  logic signed [CW-1:0] x_c    [L+1];
  logic signed [CW-1:0] y_c    [L+1];
  logic [Z_W-1:0]       z_c    [L+1];
  logic [2*DW-1:0]      rem_c  [L+1];
  logic [DW-1:0]        root_c [L+1];
  logic                 accept;
  logic [ANG_W-1:0]     angle_u;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  r2p_prep #(
    .DW (DW),
    .CW (CW)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .real_part_i (real_part_i),
    .imag_part_i (imag_part_i),
    .ctl_o       (ctl_c[0]),
    .x_o         (x_c[0]),
    .y_o         (y_c[0]),
    .z_o         (z_c[0]),
    .rem_o       (rem_c[0])
  );

  assign root_c[0] = '0;

  for (genvar k = 0; k < L; k++) begin : g_cell
    r2p_cell #(
      .DW    (DW),
      .CW    (CW),
      .NROT  (NROT),
      .STAGE (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_c[k]),
      .x_i    (x_c[k]),
      .y_i    (y_c[k]),
      .z_i    (z_c[k]),
      .rem_i  (rem_c[k]),
      .root_i (root_c[k]),
      .ctl_o  (ctl_c[k+1]),
      .x_o    (x_c[k+1]),
      .y_o    (y_c[k+1]),
      .z_o    (z_c[k+1]),
      .rem_o  (rem_c[k+1]),
      .root_o (root_c[k+1])
    );
  end

  r2p_round #(
    .DW (DW)
  ) u_round (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl_c[L]),
    .z_i         (z_c[L]),
    .rem_i       (rem_c[L]),
    .root_i      (root_c[L]),
    .done_o      (done_o),
    .magnitude_o (magnitude_o),
    .angle_o     (angle_u)
  );

  assign angle_o = angle_u;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("accepted transaction not delivered after pipeline latency");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("result strobe without matching accepted transaction");

  a_zero_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && magnitude_o == '0 |-> angle_u == ANG_ZERO)
    else $error("zero magnitude with nonzero angle");

  a_pos_imag_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && real_part_i == '0 && !imag_part_i[DW-1] && imag_part_i != '0
      |-> ##LAT angle_u == ANG_HALF_PI)
    else $error("positive imaginary axis not mapped to half pi");

endmodule

### hdl/r2p_prep.sv
// ----------------------------------------------------------------------------
// r2p_prep
// entry stages: squares, axis cases and rotation start values, then the sum
// of squares that feeds the square root digits
// ----------------------------------------------------------------------------
module r2p_prep import r2p_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF,
  parameter int CW = DATA_WIDTH_DEF + FRAC_BITS + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic signed [DW-1:0] real_part_i,
  input  logic signed [DW-1:0] imag_part_i,
  output r2p_ctl_t             ctl_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic [Z_W-1:0]       z_o,
  output logic [2*DW-1:0]      rem_o
);

  r2p_ctl_t              ctl1_d, ctl1_q, ctl2_q;
  logic [DW-1:0]         are, aim;
  logic [2*DW-1:0]       sq_re_d, sq_im_d, sq_re_q, sq_im_q, rem_q;
  logic signed [CW-1:0]  xe, ye;
  logic signed [CW-1:0]  x1_d, y1_d, x1_q, y1_q, x2_q, y2_q;
  logic [Z_W-1:0]        z1_d, z1_q, z2_q;
  logic                  re_zero, im_zero, re_neg;

  assign re_zero = (real_part_i == '0);
  assign im_zero = (imag_part_i == '0);
  assign re_neg  = real_part_i[DW-1];

  assign are = imag_part_i[DW-1] ? DW'(-imag_part_i) : DW'(imag_part_i);
  assign aim = re_neg ? DW'(-real_part_i) : DW'(real_part_i);
  assign sq_re_d = (2*DW)'(aim) * (2*DW)'(aim);
  assign sq_im_d = (2*DW)'(are) * (2*DW)'(are);

  assign xe = CW'(real_part_i) <<< FRAC_BITS;
  assign ye = CW'(imag_part_i) <<< FRAC_BITS;

  always_comb begin
    // left half plane: turn by pi before vectoring
    if (re_neg) begin
      x1_d = -xe;
      y1_d = -ye;
      z1_d = Z_PI;
    end else begin
      x1_d = xe;
      y1_d = ye;
      z1_d = '0;
    end
  end

  always_comb begin
    ctl1_d.valid      = accept_i;
    ctl1_d.special    = re_zero | im_zero;
    ctl1_d.spec_angle = ANG_ZERO;
    if (re_zero && !im_zero) begin
      ctl1_d.spec_angle = imag_part_i[DW-1] ? ANG_NEG_HALF_PI : ANG_HALF_PI;
    end else if (im_zero && !re_zero) begin
      ctl1_d.spec_angle = re_neg ? ANG_PI : ANG_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= ctl1_d;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_re_q <= sq_re_d;
    sq_im_q <= sq_im_d;
    x1_q    <= x1_d;
    y1_q    <= y1_d;
    z1_q    <= z1_d;
    rem_q   <= sq_re_q + sq_im_q;
    x2_q    <= x1_q;
    y2_q    <= y1_q;
    z2_q    <= z1_q;
  end

  assign ctl_o = ctl2_q;
  assign x_o   = x2_q;
  assign y_o   = y2_q;
  assign z_o   = z2_q;
  assign rem_o = rem_q;

endmodule

### hdl/r2p_cell.sv
// ----------------------------------------------------------------------------
// r2p_cell
// one pipeline cell: one vectoring rotation and one square root digit,
// each present only where its stage index falls inside its range
// ----------------------------------------------------------------------------
module r2p_cell import r2p_pkg::*; #(
  parameter int DW    = DATA_WIDTH_DEF,
  parameter int CW    = DATA_WIDTH_DEF + FRAC_BITS + 2,
  parameter int NROT  = ITERATIONS_DEF,
  parameter int STAGE = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  r2p_ctl_t             ctl_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic [Z_W-1:0]       z_i,
  input  logic [2*DW-1:0]      rem_i,
  input  logic [DW-1:0]        root_i,
  output r2p_ctl_t             ctl_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic [Z_W-1:0]       z_o,
  output logic [2*DW-1:0]      rem_o,
  output logic [DW-1:0]        root_o
);

  localparam int RW = 2 * DW + 1;

  r2p_ctl_t             ctl_q;
  logic signed [CW-1:0] x_d, y_d, x_q, y_q;
  logic [Z_W-1:0]       z_d, z_q;
  logic [2*DW-1:0]      rem_d, rem_q;
  logic [DW-1:0]        root_d, root_q;

  if (STAGE < NROT) begin : g_rot
    logic signed [CW-1:0] dx, dy;
    assign dx = y_i >>> STAGE;
    assign dy = x_i >>> STAGE;
    always_comb begin
      if (!y_i[CW-1]) begin
        x_d = x_i + dx;
        y_d = y_i - dy;
        z_d = z_i + ATAN_TAB[STAGE];
      end else begin
        x_d = x_i - dx;
        y_d = y_i + dy;
        z_d = z_i - ATAN_TAB[STAGE];
      end
    end
  end else begin : g_rot_pass
    assign x_d = x_i;
    assign y_d = y_i;
    assign z_d = z_i;
  end

  if (STAGE < DW) begin : g_sqrt
    localparam int B = DW - 1 - STAGE;
    logic [RW-1:0] trial, rem_ext;
    logic          fits;
    // (root + 2^B)^2 - root^2
    assign trial   = (RW'(root_i) << (B + 1)) | (RW'(1) << (2 * B));
    assign rem_ext = RW'(rem_i);
    assign fits    = (rem_ext >= trial);
    assign rem_d   = fits ? (2*DW)'(rem_ext - trial) : rem_i;
    assign root_d  = fits ? (root_i | (DW'(1) << B)) : root_i;
  end else begin : g_sqrt_pass
    assign rem_d  = rem_i;
    assign root_d = root_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign ctl_o  = ctl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

### hdl/r2p_round.sv
// ----------------------------------------------------------------------------
// r2p_round
// output stage: magnitude rounding, angle rounding and axis overrides
// ----------------------------------------------------------------------------
module r2p_round import r2p_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  r2p_ctl_t         ctl_i,
  input  logic [Z_W-1:0]   z_i,
  input  logic [2*DW-1:0]  rem_i,
  input  logic [DW-1:0]    root_i,
  output logic             done_o,
  output logic [DW-1:0]    magnitude_o,
  output logic [ANG_W-1:0] angle_o
);

  logic             done_q;
  logic [DW-1:0]    mag_d, mag_q;
  logic [ANG_W-1:0] ang_d, ang_q;
  logic [Z_W-1:0]   z_rnd;

  assign mag_d = (rem_i > (2*DW)'(root_i)) ? root_i + DW'(1) : root_i;
  assign z_rnd = z_i + Z_ROUND;
  assign ang_d = ctl_i.special ? ctl_i.spec_angle : z_rnd[Z_W-1 -: ANG_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    ang_q <= ang_d;
  end

  assign done_o      = done_q;
  assign magnitude_o = mag_q;
  assign angle_o     = ang_q;

endmodule

### verif/r2p_polar_check.sv
// ----------------------------------------------------------------------------
// r2p_polar_check
// watches the sample and result channels of rect_to_polar, predicts the
// rounded magnitude and cordic binary angle of every accepted sample and
// compares each strobed result, field by field, with the oldest prediction
// ----------------------------------------------------------------------------
module r2p_polar_check import r2p_pkg::*; #(
  parameter int ITERATIONS = 16,
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic signed [DATA_WIDTH-1:0] real_part_i,
  input  logic signed [DATA_WIDTH-1:0] imag_part_i,
  input  logic                         done_i,
  input  logic [DATA_WIDTH-1:0]        magnitude_i,
  input  logic signed [ANG_W-1:0]      angle_i,
  output int                           mismatches_o,
  output int                           pending_o
);

  localparam int FRACB     = 30;
  localparam int LUT_DEPTH = 24;
  localparam int MAX_SHOWN = 10;

  // arctangent of 2^-i, 2^32 counts per turn
  localparam logic [31:0] ATAN_LUT [LUT_DEPTH] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] re;
    logic signed [DATA_WIDTH-1:0] im;
    logic [DATA_WIDTH-1:0]        mag;
    logic signed [ANG_W-1:0]      ang;
  } polar_t;

  polar_t polar_q[$];
  int     err_cnt;

  function automatic polar_t predict_polar(logic signed [DATA_WIDTH-1:0] re,
                                           logic signed [DATA_WIDTH-1:0] im);
    polar_t      p;
    longint      sre, sim, n, root, cand, x, y, dx, dy;
    logic [31:0] z, zr;
    int          steps;
    sre = longint'(re);
    sim = longint'(im);
    p.re = re;
    p.im = im;
    // integer square root, then round to nearest
    n = sre * sre + sim * sim;
    root = 0;
    for (int b = DATA_WIDTH - 1; b >= 0; b--) begin
      cand = root | (64'sd1 << b);
      if (cand * cand <= n) root = cand;
    end
    if (n - root * root > root) root = root + 1;
    p.mag = root[DATA_WIDTH-1:0];
    if (sre == 0 && sim == 0) begin
      p.ang = 16'sh0000;
    end else if (sre == 0) begin
      p.ang = (sim > 0) ? 16'sh4000 : 16'shC000;
    end else if (sim == 0) begin
      p.ang = (sre > 0) ? 16'sh0000 : 16'sh8000;
    end else begin
      x = sre <<< FRACB;
      y = sim <<< FRACB;
      z = 32'h0000_0000;
      // left half plane: turn by pi first
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      steps = (ITERATIONS < LUT_DEPTH) ? ITERATIONS : LUT_DEPTH;
      for (int i = 0; i < steps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_LUT[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_LUT[i];
        end
      end
      zr = z + 32'h0000_8000;
      p.ang = zr[31:16];
    end
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    polar_t want;
    if (!rst_ni) begin
      polar_q.delete();
      err_cnt = 0;
      mismatches_o <= 0;
      pending_o <= 0;
    end else begin
      if (done_i) begin
        if (polar_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN)
            $display("%0t: unexpected result transaction mag=%0d ang=%0d",
                     $realtime, magnitude_i, angle_i);
        end else begin
          want = polar_q.pop_front();
          if (magnitude_i !== want.mag || angle_i !== want.ang) begin
            err_cnt++;
            if (err_cnt <= MAX_SHOWN)
              $display("%0t: re=%0d im=%0d expected mag=%0d ang=%0d, got mag=%0d ang=%0d",
                       $realtime, want.re, want.im, want.mag, want.ang,
                       magnitude_i, angle_i);
          end
        end
      end
      if (start_i && !busy_i) polar_q.push_back(predict_polar(real_part_i, imag_part_i));
      mismatches_o <= err_cnt;
      pending_o <= polar_q.size();
    end
  end

endmodule

### verif/tb_rect_to_polar.sv
// ----------------------------------------------------------------------------
// tb_rect_to_polar
// drives directed and random complex samples into rect_to_polar under three
// sender idling profiles, lets r2p_polar_check predict and compare the
// results, and reports the verdict, counting a stall of the block as a mismatch
// ----------------------------------------------------------------------------
module tb_rect_to_polar import r2p_pkg::*;;

  localparam int ITER     = 16;
  localparam int DW       = 16;
  localparam int LATENCY  = 3 + ((ITER > DW) ? ITER : DW);
  localparam int STALL_MAX = 2000;
  localparam int PHASE_ITEMS = 470;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic signed [DW-1:0]   real_part = '0;
  logic signed [DW-1:0]   imag_part = '0;
  logic                   done;
  logic [DW-1:0]          magnitude;
  logic signed [ANG_W-1:0] angle;
  int                     mismatches;
  int                     pending;
  int                     idle_pct = 0;
  int                     stall_cnt = 0;

  always #4 clk_i = ~clk_i;

  rect_to_polar #(.ITERATIONS(ITER), .DATA_WIDTH(DW)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .real_part_i (real_part),
    .imag_part_i (imag_part),
    .done_o      (done),
    .magnitude_o (magnitude),
    .angle_o     (angle)
  );

  r2p_polar_check #(.ITERATIONS(ITER), .DATA_WIDTH(DW)) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .real_part_i  (real_part),
    .imag_part_i  (imag_part),
    .done_i       (done),
    .magnitude_i  (magnitude),
    .angle_i      (angle),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // stall watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_MAX) begin
      $display("rect_to_polar: mismatch");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic send_sample(input logic signed [DW-1:0] re, input logic signed [DW-1:0] im);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    real_part <= re;
    imag_part <= im;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic send_random();
    logic signed [DW-1:0] re, im;
    logic signed [DW-1:0] corner [6];
    corner = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFF};
    re = DW'($urandom);
    im = DW'($urandom);
    case ($urandom_range(9))
      4: begin
        re = DW'($signed(5'($urandom_range(31))));
        im = DW'($signed(5'($urandom_range(31))));
      end
      5: begin
        if ($urandom_range(1)) re = '0;
        else im = '0;
      end
      6: begin
        // close to the negative real axis, where the angle wraps around pi
        re = DW'(-$signed(17'($urandom_range(32768, 1024))));
        im = DW'($signed(4'($urandom_range(15))));
      end
      7: begin
        re = corner[$urandom_range(5)];
        im = corner[$urandom_range(5)];
      end
      8: begin
        re = DW'($signed(8'($urandom)));
        im = DW'($signed(8'($urandom)));
      end
      9: begin
        im = $urandom_range(1) ? re : -re;
      end
      default: ;
    endcase
    send_sample(re, im);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero, axes, corners, diagonals, near pi
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd1);
    send_sample(16'sd0, -16'sd1);
    send_sample(16'sd0, 16'sh7FFF);
    send_sample(16'sd0, 16'sh8000);
    send_sample(16'sd1, 16'sd0);
    send_sample(-16'sd1, 16'sd0);
    send_sample(16'sh7FFF, 16'sd0);
    send_sample(16'sh8000, 16'sd0);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sd1);
    send_sample(16'sh8000, -16'sd1);
    send_sample(16'sh8001, 16'sd1);
    send_sample(16'sd1, 16'sd1);
    send_sample(-16'sd1, 16'sd1);
    send_sample(-16'sd1, -16'sd1);
    send_sample(16'sd1, -16'sd1);
    send_sample(16'sh5555, -16'sh2AAB);
    wait_drained();

    idle_pct = 13;
    repeat (PHASE_ITEMS) send_random();
    wait_drained();
    idle_pct = 54;
    repeat (PHASE_ITEMS) send_random();
    wait_drained();
    idle_pct = 0;
    repeat (PHASE_ITEMS) send_random();
    wait_drained();
    repeat (2 * LATENCY) @(posedge clk_i);

    if (mismatches == 0 && pending == 0)
      $display("rect_to_polar: match");
    else
      $display("rect_to_polar: mismatch");
    $finish;
  end

endmodule

### sim.f
hdl/r2p_pkg.sv
hdl/r2p_prep.sv
hdl/r2p_cell.sv
hdl/r2p_round.sv
hdl/rect_to_polar.sv
verif/r2p_polar_check.sv
verif/tb_rect_to_polar.sv
